// ===== src/rv32_pkg.sv =====
`timescale 1ns / 1ps
package rv32_pkg;
   localparam int DATA_WIDTH = 32;
   localparam int REG_COUNT  = 32;
   localparam int REG_AW     = 5;
   localparam logic [31:0] INSTR_STEP = 32'd4;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_EXIT  = 2'd1;
   localparam logic [1:0] CSR_PRINT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_DIV, ST_MUL, ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_start;
      logic div_step;
      logic mul_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic is_mul;
      logic div_last;
   } status_type;
endpackage

// ===== src/rv32_ctrl.sv =====
`timescale 1ns / 1ps
module rv32_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rv32_pkg::status_type status,
   output rv32_pkg::cmd_type    cmd
);
   import rv32_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (status.is_div) state_in = ST_DIV;
            else if (status.is_mul) state_in = ST_MUL;
            else state_in = ST_DONE;
         end
         ST_DIV: if (status.div_last) state_in = ST_DONE;
         ST_MUL: state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cmd.div_start = status.is_div;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_MUL: cmd.mul_step = 1'b1;
         ST_DONE: begin
            rsp_valid = 1'b1;
            cmd.commit = rsp_ready;
         end
         default: ;
      endcase
   end
endmodule

// ===== src/rv32_datapath.sv =====
`timescale 1ns / 1ps
module rv32_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rv32_pkg::cmd_type    cmd,
   output rv32_pkg::status_type status,
   input  logic                 req_action,
   input  logic [31:0]          req_instr_word,
   input  logic [31:0]          req_load_value,
   input  logic                 cfg_we,
   input  logic [1:0]           cfg_idx,
   input  logic [31:0]          cfg_data,
   output logic [31:0]          start_address,
   output logic [31:0]          exit_code,
   output logic [31:0]          print_code,
   output logic [31:0]          rsp_pc_after,
   output logic                 rsp_wb_valid,
   output logic [4:0]           rsp_wb_index,
   output logic [31:0]          rsp_wb_value,
   output logic [1:0]           rsp_mem_op,
   output logic [31:0]          rsp_mem_addr,
   output logic [2:0]           rsp_mem_size,
   output logic [31:0]          rsp_mem_wdata,
   output logic                 rsp_halted,
   output logic                 rsp_char_valid,
   output logic [7:0]           rsp_char_value,
   output logic                 rsp_illegal_opcode
);
   import rv32_pkg::*;

   logic [31:0] regs_ff [REG_COUNT];
   logic [31:0] pc_ff, start_ff, exit_ff, print_ff;
   logic        pend_ff;
   logic [4:0]  ldest_ff;
   logic        act_ff;
   logic [31:0] w_ff, ldv_ff;

   logic [31:0] pc_after_ff, wbv_ff, maddr_ff, mwdata_ff;
   logic        wbvalid_ff, halted_ff, cv_ff, ill_ff, pend_in_ff;
   logic [4:0]  wbi_ff, ldest_in_ff;
   logic [1:0]  mop_ff;
   logic [2:0]  msize_ff;
   logic [7:0]  cval_ff;

   logic [31:0] rem_ff, quo_ff, dvs_ff;
   logic [4:0]  dcnt_ff;
   logic        negq_ff, negr_ff, dspec_ff;
   logic [31:0] dspec_val_ff;
   logic [1:0]  mf_ff;
   logic [31:0] ma_ff, mb_ff;
   logic        mas_ff, mbs_ff;

   function automatic logic reg_ok(input logic [4:0] i);
      return i != '0 && 32'(i) < REG_COUNT;
   endfunction

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, alu_b, alu_res;
   logic [31:0] a0_val, a1_val;
   logic        alt, alu_wr, take, is_md;

   assign opc = w_ff[6:0];
   assign rd  = w_ff[11:7];
   assign f3  = w_ff[14:12];
   assign a = reg_ok(w_ff[19:15]) ? regs_ff[w_ff[19:15]] : 32'd0;
   assign b = reg_ok(w_ff[24:20]) ? regs_ff[w_ff[24:20]] : 32'd0;
   assign a0_val = reg_ok(5'd10) ? regs_ff[5'd10] : 32'd0;
   assign a1_val = reg_ok(5'd11) ? regs_ff[5'd11] : 32'd0;
   assign imm_i = {{20{w_ff[31]}}, w_ff[31:20]};
   assign imm_s = {{20{w_ff[31]}}, w_ff[31:25], w_ff[11:7]};
   assign imm_b = {{19{w_ff[31]}}, w_ff[31], w_ff[7], w_ff[30:25], w_ff[11:8], 1'b0};
   assign imm_j = {{11{w_ff[31]}}, w_ff[31], w_ff[19:12], w_ff[20], w_ff[30:21], 1'b0};
   assign is_md = !act_ff && opc == OPC_OP && w_ff[25];
   assign alt = (opc == OPC_OP) ? w_ff[30] : (f3 == 3'd5 && w_ff[30]);
   assign alu_b = (opc == OPC_OP) ? b : imm_i;

   always_comb begin
      alu_wr = !(alt && f3 != 3'd0 && f3 != 3'd5);
      case (f3)
         3'd0: alu_res = alt ? a - alu_b : a + alu_b;
         3'd1: alu_res = a << alu_b[4:0];
         3'd2: alu_res = {31'd0, $signed(a) < $signed(alu_b)};
         3'd3: alu_res = {31'd0, a < alu_b};
         3'd4: alu_res = a ^ alu_b;
         3'd5: alu_res = alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
         3'd6: alu_res = a | alu_b;
         default: alu_res = a & alu_b;
      endcase
      case (f3)
         3'd0: take = a == b;
         3'd1: take = a != b;
         3'd4: take = $signed(a) < $signed(b);
         3'd5: take = !($signed(a) < $signed(b));
         3'd6: take = a < b;
         3'd7: take = a >= b;
         default: take = 1'b0;
      endcase
   end

   assign status.is_div = is_md && f3[2];
   assign status.is_mul = is_md && !f3[2];
   assign status.div_last = dcnt_ff == 5'd31;

   // divider: restoring, one bit per cycle on magnitudes
   logic [32:0] trial;
   logic [31:0] ua, ub;
   assign ua = (!f3[0] && a[31]) ? 32'd0 - a : a;
   assign ub = (!f3[0] && b[31]) ? 32'd0 - b : b;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   // remainder path; its sign fix is applied when the result is formed
   logic [31:0] rem_next;
   assign rem_next = trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];

   // multiplier: 33x33 signed, combinational on the registered operands
   logic signed [65:0] prod;
   assign prod = $signed({mas_ff & ma_ff[31], ma_ff}) * $signed({mbs_ff & mb_ff[31], mb_ff});

   logic [31:0] div_q, div_r, md_res;
   assign div_q = negq_ff ? 32'd0 - quo_ff : quo_ff;
   assign div_r = negr_ff ? 32'd0 - rem_ff : rem_ff;

   always_comb begin
      md_res = '0;
      if (cmd.div_step && status.div_last) begin
         if (dspec_ff) md_res = dspec_val_ff;
         else if (mf_ff[1]) md_res = negr_ff ? 32'd0 - rem_next : rem_next;
         else md_res = div_q;
      end
      if (cmd.mul_step) md_res = (mf_ff == 2'd0) ? prod[31:0] : prod[63:32];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         w_ff   <= req_instr_word;
         ldv_ff <= req_load_value;
      end
      if (cmd.exec) begin
         pc_after_ff <= pc_ff + INSTR_STEP;
         wbvalid_ff <= 1'b0; wbi_ff <= '0; wbv_ff <= '0;
         mop_ff <= MEM_NONE; maddr_ff <= '0; msize_ff <= '0; mwdata_ff <= '0;
         halted_ff <= 1'b0; cv_ff <= 1'b0; cval_ff <= '0; ill_ff <= 1'b0;
         pend_in_ff <= pend_ff; ldest_in_ff <= ldest_ff;
         ma_ff <= a; mb_ff <= b;
         mas_ff <= f3[1:0] != 2'd3; mbs_ff <= f3[1:0] == 2'd1;
         mf_ff <= f3[1:0];
         if (act_ff) begin
            pc_after_ff <= pc_ff;
            if (pend_ff) begin
               pend_in_ff <= 1'b0;
               wbv_ff <= ldv_ff; wbi_ff <= ldest_ff; wbvalid_ff <= 1'b1;
            end
         end else begin
            case (opc)
               OPC_OP: begin
                  wbi_ff <= rd;
                  if (!w_ff[25]) begin wbvalid_ff <= alu_wr; wbv_ff <= alu_res; end
                  else wbvalid_ff <= 1'b1;
               end
               OPC_OPIMM: begin wbi_ff <= rd; wbvalid_ff <= alu_wr; wbv_ff <= alu_res; end
               OPC_LOAD: begin
                  mop_ff <= MEM_READ; maddr_ff <= a + imm_i; msize_ff <= f3;
                  pend_in_ff <= 1'b1; ldest_in_ff <= rd;
               end
               OPC_STORE: begin
                  mop_ff <= MEM_WRITE; maddr_ff <= a + imm_s; msize_ff <= f3;
                  mwdata_ff <= b;
               end
               OPC_BRANCH: if (take) pc_after_ff <= pc_ff + imm_b;
               OPC_FENCE: ;
               OPC_AUIPC: begin
                  wbi_ff <= rd; wbvalid_ff <= 1'b1; wbv_ff <= pc_ff + {w_ff[31:12], 12'd0};
               end
               OPC_LUI: begin wbi_ff <= rd; wbvalid_ff <= 1'b1; wbv_ff <= {w_ff[31:12], 12'd0}; end
               OPC_JAL: begin
                  pc_after_ff <= pc_ff + imm_j;
                  wbi_ff <= rd; wbvalid_ff <= 1'b1; wbv_ff <= pc_ff + INSTR_STEP;
               end
               OPC_JALR: begin
                  pc_after_ff <= (a + imm_i) & ~32'd1;
                  wbi_ff <= rd; wbvalid_ff <= 1'b1; wbv_ff <= pc_ff + INSTR_STEP;
               end
               OPC_SYSTEM: begin
                  if (f3 == 3'd0) begin
                     if (w_ff[31:20] == 12'd1) halted_ff <= 1'b1;
                     else if (w_ff[31:20] == 12'd0) begin
                        if (a0_val == exit_ff) halted_ff <= 1'b1;
                        else if (a0_val == print_ff) begin
                           cv_ff <= 1'b1; cval_ff <= a1_val[7:0];
                        end
                     end
                  end
               end
               default: ill_ff <= 1'b1;
            endcase
         end
      end
      if (cmd.div_start) begin
         rem_ff <= '0; quo_ff <= ua; dvs_ff <= ub; dcnt_ff <= '0;
         negq_ff <= !f3[0] && (a[31] ^ b[31]);
         negr_ff <= !f3[0] && a[31];
         dspec_ff <= 1'b1;
         if (b == '0) dspec_val_ff <= f3[1] ? a : '1;
         else if (!f3[0] && a == 32'h8000_0000 && b == '1)
            dspec_val_ff <= f3[1] ? '0 : a;
         else dspec_ff <= 1'b0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_next;
         quo_ff <= {quo_ff[30:0], !trial[32]};
         dcnt_ff <= dcnt_ff + 5'd1;
         if (status.div_last) wbv_ff <= mf_ff[1] ? md_res
                                     : (dspec_ff ? dspec_val_ff
                                        : (negq_ff ? 32'd0 - {quo_ff[30:0], !trial[32]}
                                                   : {quo_ff[30:0], !trial[32]}));
      end
      if (cmd.mul_step) wbv_ff <= md_res;
      if (cmd.commit && wbvalid_ff && wbi_ff != '0 && 32'(wbi_ff) < REG_COUNT)
         regs_ff[wbi_ff[REG_AW-1:0]] <= wbv_ff;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) regs_ff[i] <= '0;
         pc_ff <= '0; start_ff <= '0; exit_ff <= 32'd10; print_ff <= 32'd11;
         pend_ff <= 1'b0; ldest_ff <= '0;
      end else begin
         if (cmd.commit) begin
            pc_ff <= pc_after_ff;
            pend_ff <= pend_in_ff;
            ldest_ff <= ldest_in_ff;
         end
         if (cfg_we) begin
            case (cfg_idx)
               CSR_START: begin start_ff <= cfg_data; pc_ff <= cfg_data; end
               CSR_EXIT:  exit_ff <= cfg_data;
               CSR_PRINT: print_ff <= cfg_data;
               default: ;
            endcase
         end
      end
   end

   logic wb_eff;
   assign wb_eff = wbvalid_ff && wbi_ff != '0 && 32'(wbi_ff) < REG_COUNT;
   assign start_address = start_ff;
   assign exit_code = exit_ff;
   assign print_code = print_ff;
   assign rsp_pc_after = pc_after_ff;
   assign rsp_wb_valid = wb_eff;
   assign rsp_wb_index = wb_eff ? wbi_ff : '0;
   assign rsp_wb_value = wb_eff ? wbv_ff : '0;
   assign rsp_mem_op = mop_ff;
   assign rsp_mem_addr = maddr_ff;
   assign rsp_mem_size = msize_ff;
   assign rsp_mem_wdata = mwdata_ff;
   assign rsp_halted = halted_ff;
   assign rsp_char_valid = cv_ff;
   assign rsp_char_value = cval_ff;
   assign rsp_illegal_opcode = ill_ff;
endmodule

// ===== src/rv32im_instruction_execute.sv =====
`timescale 1ns / 1ps
// Each item passes the states accept, execute and result; multiply adds a multiply step,
// divide and remainder add the steps of the one-bit-per-cycle divider.
// Throughput: one item at a time; next item accepted after the result is taken.
// Reset (synchronous): registers x1..x31 cleared, pc = start_address = 0,
// exit code 10, print code 11, no load pending.
module rv32im_instruction_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pc_after,
   output logic        rsp_wb_valid,
   output logic [4:0]  rsp_wb_index,
   output logic [31:0] rsp_wb_value,
   output logic [1:0]  rsp_mem_op,
   output logic [31:0] rsp_mem_addr,
   output logic [2:0]  rsp_mem_size,
   output logic [31:0] rsp_mem_wdata,
   output logic        rsp_halted,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_value,
   output logic        rsp_illegal_opcode,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rv32_pkg::*;
   cmd_type    cmd;
   status_type status;
   logic [31:0] sa, ec, pc_code;
   logic [1:0]  ridx;

   assign ridx = paddr[3:2];
   assign pready = 1'b1;

   always_comb begin
      case (ridx)
         CSR_START: prdata = sa;
         CSR_EXIT:  prdata = ec;
         CSR_PRINT: prdata = pc_code;
         default:   prdata = '0;
      endcase
   end

   rv32_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .status, .cmd
   );

   rv32_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_action, .req_instr_word, .req_load_value,
      .cfg_we(psel && penable && pwrite), .cfg_idx(ridx), .cfg_data(pwdata),
      .start_address(sa), .exit_code(ec), .print_code(pc_code),
      .rsp_pc_after, .rsp_wb_valid, .rsp_wb_index, .rsp_wb_value,
      .rsp_mem_op, .rsp_mem_addr, .rsp_mem_size, .rsp_mem_wdata,
      .rsp_halted, .rsp_char_valid, .rsp_char_value, .rsp_illegal_opcode
   );
endmodule

// ===== sim/rv32im_exec_checker.sv =====
`timescale 1ns / 1ps
module rv32im_exec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_load_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pc_after,
   input  logic        rsp_wb_valid,
   input  logic [4:0]  rsp_wb_index,
   input  logic [31:0] rsp_wb_value,
   input  logic [1:0]  rsp_mem_op,
   input  logic [31:0] rsp_mem_addr,
   input  logic [2:0]  rsp_mem_size,
   input  logic [31:0] rsp_mem_wdata,
   input  logic        rsp_halted,
   input  logic        rsp_char_valid,
   input  logic [7:0]  rsp_char_value,
   input  logic        rsp_illegal_opcode,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending,
   output int          retired
);
   import rv32_pkg::*;

   typedef struct packed {
      logic [31:0] pc_after;
      logic        wb_valid;
      logic [4:0]  wb_index;
      logic [31:0] wb_value;
      logic [1:0]  mem_op;
      logic [31:0] mem_addr;
      logic [2:0]  mem_size;
      logic [31:0] mem_wdata;
      logic        halted;
      logic        char_valid;
      logic [7:0]  char_value;
      logic        illegal;
   } outcome_type;

   outcome_type expected_q[$];
   logic [31:0] regs[32];
   logic [31:0] pc, exit_code, print_code;
   logic        ld_busy;
   logic [4:0]  ld_rd;

   function automatic logic [31:0] rd_reg(logic [4:0] i);
      return (i == 0) ? 32'd0 : regs[i];
   endfunction

   function automatic logic [31:0] alu(logic [2:0] f3, logic alt, logic [31:0] a,
                                       logic [31:0] b);
      case (f3)
         3'd0: return alt ? a - b : a + b;
         3'd1: return a << b[4:0];
         3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         3'd3: return (a < b) ? 32'd1 : 32'd0;
         3'd4: return a ^ b;
         3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: return a | b;
         default: return a & b;
      endcase
   endfunction

   function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
      logic signed [63:0] sa, sb;
      logic [63:0] p;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      case (f3)
         3'd0: return a * b;
         3'd1: begin p = sa * sb; return p[63:32]; end
         3'd2: begin p = sa * $signed({32'd0, b}); return p[63:32]; end
         3'd3: begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
         3'd4: begin
            if (b == 0) return 32'hFFFF_FFFF;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
            return 32'($signed(a) / $signed(b));
         end
         3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
         3'd6: begin
            if (b == 0) return a;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
            return 32'($signed(a) % $signed(b));
         end
         default: return (b == 0) ? a : a % b;
      endcase
   endfunction

   function automatic outcome_type execute_item(logic act, logic [31:0] w, logic [31:0] ldv);
      outcome_type o;
      logic [31:0] a, b, imm_i, res, nxt, tgt, a1;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic        wr, take;
      o = '0;
      rd = w[11:7];
      f3 = w[14:12];
      a = rd_reg(w[19:15]);
      b = rd_reg(w[24:20]);
      a1 = rd_reg(5'd11);
      imm_i = {{20{w[31]}}, w[31:20]};
      nxt = pc + INSTR_STEP;
      wr = 1'b0;
      res = '0;
      if (act) begin
         nxt = pc;
         if (ld_busy) begin
            ld_busy = 1'b0;
            rd = ld_rd;
            res = ldv;
            wr = 1'b1;
         end
      end else begin
         case (w[6:0])
            OPC_OP: begin
               if (w[25]) begin
                  res = muldiv(f3, a, b);
                  wr = 1'b1;
               end else begin
                  wr = !(w[30] && f3 != 3'd0 && f3 != 3'd5);
                  res = alu(f3, w[30], a, b);
               end
            end
            OPC_OPIMM: begin
               wr = 1'b1;
               res = alu(f3, f3 == 3'd5 && w[30], a, imm_i);
            end
            OPC_LOAD: begin
               o.mem_op = MEM_READ;
               o.mem_addr = a + imm_i;
               o.mem_size = f3;
               ld_busy = 1'b1;
               ld_rd = rd;
            end
            OPC_STORE: begin
               o.mem_op = MEM_WRITE;
               o.mem_addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
               o.mem_size = f3;
               o.mem_wdata = b;
            end
            OPC_BRANCH: begin
               case (f3)
                  3'd0: take = a == b;
                  3'd1: take = a != b;
                  3'd4: take = $signed(a) < $signed(b);
                  3'd5: take = !($signed(a) < $signed(b));
                  3'd6: take = a < b;
                  3'd7: take = a >= b;
                  default: take = 1'b0;
               endcase
               tgt = pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
               if (take) nxt = tgt;
            end
            OPC_FENCE: ;
            OPC_AUIPC: begin wr = 1'b1; res = pc + {w[31:12], 12'd0}; end
            OPC_LUI: begin wr = 1'b1; res = {w[31:12], 12'd0}; end
            OPC_JAL: begin
               nxt = pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
               wr = 1'b1;
               res = pc + INSTR_STEP;
            end
            OPC_JALR: begin
               nxt = (a + imm_i) & ~32'd1;
               wr = 1'b1;
               res = pc + INSTR_STEP;
            end
            OPC_SYSTEM: begin
               if (f3 == 3'd0) begin
                  if (w[31:20] == 12'd1) o.halted = 1'b1;
                  else if (w[31:20] == 12'd0) begin
                     if (rd_reg(5'd10) == exit_code) o.halted = 1'b1;
                     else if (rd_reg(5'd10) == print_code) begin
                        o.char_valid = 1'b1;
                        o.char_value = a1[7:0];
                     end
                  end
               end
            end
            default: o.illegal = 1'b1;
         endcase
      end
      if (wr && rd != 0) begin
         regs[rd] = res;
         o.wb_valid = 1'b1;
         o.wb_index = rd;
         o.wb_value = res;
      end
      pc = nxt;
      o.pc_after = nxt;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type e, got;
      if (reset) begin
         for (int i = 0; i < 32; i++) regs[i] = '0;
         pc = '0;
         exit_code = 32'd10;
         print_code = 32'd11;
         ld_busy = 1'b0;
         ld_rd = '0;
         expected_q.delete();
         errors = 0;
         retired = 0;
         pending = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_START: begin pc = pwdata; end
               CSR_EXIT: exit_code = pwdata;
               CSR_PRINT: print_code = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pc_after, rsp_wb_valid, rsp_wb_index, rsp_wb_value, rsp_mem_op,
                   rsp_mem_addr, rsp_mem_size, rsp_mem_wdata, rsp_halted, rsp_char_valid,
                   rsp_char_value, rsp_illegal_opcode};
            retired++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%t: unexpected item, actual %h", $realtime, got);
            end else begin
               e = expected_q.pop_front();
               if (got !== e) begin
                  errors++;
                  $display("%t: mismatch expected %p", $realtime, e);
                  $display("%t:          actual   %p", $realtime, got);
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(execute_item(req_action, req_instr_word, req_load_value));
         pending = expected_q.size();
      end
   end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import rv32_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_action = 0;
   logic [31:0] req_instr_word = 0, req_load_value = 0;
   logic        req_ready, rsp_valid, rsp_ready = 0;
   logic [31:0] rsp_pc_after, rsp_wb_value, rsp_mem_addr, rsp_mem_wdata;
   logic        rsp_wb_valid, rsp_halted, rsp_char_valid, rsp_illegal_opcode;
   logic [4:0]  rsp_wb_index;
   logic [1:0]  rsp_mem_op;
   logic [2:0]  rsp_mem_size;
   logic [7:0]  rsp_char_value;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic        pready;
   int          errors, pending, retired, sent, cycles;
   logic        stall_mode;

   always #6 clock = ~clock;

   rv32im_instruction_execute uut (.*);
   rv32im_exec_checker chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("rv32im_instruction_execute: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_mode) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= 1'b1;
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(negedge clock);
   endtask

   task automatic send(logic act, logic [31:0] w, logic [31:0] ldv);
      req_valid <= 1; req_action <= act; req_instr_word <= w; req_load_value <= ldv;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid <= 0;
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic logic [4:0] rreg();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
             5'($urandom_range(0, 12));
   endfunction

   function automatic logic [31:0] rand_instr();
      logic [4:0] rd, r1, r2;
      logic [2:0] f3;
      logic [31:0] w;
      rd = rreg(); r1 = rreg(); r2 = rreg(); f3 = 3'($urandom);
      w = $urandom;
      case ($urandom_range(0, 15))
         0, 1:   return {7'h01, r2, r1, f3, rd, OPC_OP};
         2, 3:   return {1'b0, $urandom_range(0, 1) == 1, 5'd0, r2, r1, f3, rd, OPC_OP};
         4, 5:   return {w[31:20], r1, f3, rd, OPC_OPIMM};
         6:      return {w[31:20], r1, f3, rd, OPC_LOAD};
         7:      return {w[31:25], r2, r1, f3, w[11:7], OPC_STORE};
         8:      return {w[31:25], r2, r1, f3, w[11:7], OPC_BRANCH};
         9:      return {w[31:12], rd, OPC_LUI};
         10:     return {w[31:12], rd, OPC_AUIPC};
         11:     return {w[31:12], rd, OPC_JAL};
         12:     return {w[31:20], r1, f3, rd, OPC_JALR};
         13:     return {11'd0, w[0], 13'd0, OPC_SYSTEM};
         14:     return {w[31:7], OPC_SYSTEM};
         default: return ($urandom_range(0, 1) == 1) ? {w[31:7], OPC_FENCE} : w;
      endcase
   endfunction

   task automatic random_phase(int n);
      int gap;
      while (n > 0) begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 7) == 0) send(1, $urandom, $urandom);
            else send(0, rand_instr(), $urandom);
            n--;
         end
         gap = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0) gap = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      cycles = 0; sent = 0; stall_mode = 0;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // load a few registers with extremes
      send(0, {20'h80000, 5'd1, OPC_LUI}, 0);
      send(0, {12'hFFF, 5'd0, 3'd0, 5'd2, OPC_OPIMM}, 0);
      send(0, {12'h7FF, 5'd0, 3'd0, 5'd3, OPC_OPIMM}, 0);
      send(0, {7'h01, 5'd0, 5'd1, 3'd4, 5'd4, OPC_OP}, 0);
      send(0, {7'h01, 5'd2, 5'd1, 3'd4, 5'd5, OPC_OP}, 0);
      send(0, {7'h01, 5'd2, 5'd1, 3'd6, 5'd6, OPC_OP}, 0);
      send(0, {7'h01, 5'd0, 5'd1, 3'd7, 5'd7, OPC_OP}, 0);
      send(0, {7'h01, 5'd2, 5'd2, 3'd3, 5'd8, OPC_OP}, 0);
      send(0, {7'h20, 5'd2, 5'd1, 3'd5, 5'd9, OPC_OP}, 0);
      send(0, {7'h20, 5'd2, 5'd1, 3'd4, 5'd9, OPC_OP}, 0);
      send(0, {12'd0, 5'd2, 3'd2, 5'd12, OPC_LOAD}, 0);
      send(1, 0, 32'hFFFF_FFFF);
      send(1, 0, 32'h1234_5678);
      send(0, {12'd0, 5'd2, 3'd7, 5'd0, OPC_LOAD}, 0);
      send(1, 0, 32'hAAAA_5555);
      send(0, {7'h7F, 5'd2, 5'd1, 3'd7, 5'h1F, OPC_STORE}, 0);
      send(0, {1'b1, 6'h3F, 5'd2, 5'd2, 3'd0, 4'hF, 1'b1, OPC_BRANCH}, 0);
      send(0, {7'd0, 5'd2, 5'd2, 3'd2, 5'd8, OPC_BRANCH}, 0);
      send(0, {20'hFFFFF, 5'd31, OPC_JAL}, 0);
      send(0, {12'h7FF, 5'd2, 3'd0, 5'd30, OPC_JALR}, 0);
      send(0, {12'd1, 13'd0, OPC_SYSTEM}, 0);
      send(0, {12'd10, 5'd0, 3'd0, 5'd10, OPC_OPIMM}, 0);
      send(0, {12'd0, 13'd0, OPC_SYSTEM}, 0);
      send(0, {12'd11, 5'd0, 3'd0, 5'd10, OPC_OPIMM}, 0);
      send(0, {12'd0, 13'd0, OPC_SYSTEM}, 0);
      send(0, 32'hFFFF_FFFF, 0);
      drain();
      stall_mode = 1;
      random_phase(280);
      drain();
      csr_write(CSR_START, 32'hFFFF_FFFC);
      csr_write(CSR_EXIT, 32'd0);
      csr_write(CSR_PRINT, 32'hFFFF_FFFF);
      random_phase(280);
      drain();
      stall_mode = 0;
      csr_write(CSR_START, 32'h0000_1000);
      csr_write(CSR_EXIT, 32'hFFFF_FFFF);
      csr_write(CSR_PRINT, 32'd0);
      random_phase(290);
      drain();
      $display("covered %0d items (%0d results) over three register settings", sent, retired);
      $display("ALU, M-extension, loads, stores, branches, jumps and environment calls");
      if (errors == 0) $display("rv32im_instruction_execute: match");
      else $display("rv32im_instruction_execute: mismatch");
      $finish;
   end
endmodule
